// ===== rtl/wbzhp_pkg.sv =====
// Shared types, constants and the zone mapping for the weight block zone header packer.
`default_nettype none

package wbzhp_pkg;

   localparam int unsigned  ZONE_COUNT  = 12;
   localparam int unsigned  ZONE_W      = 4;
   localparam logic [14:0]  TILE_STRIDE = 15'd37;
   localparam logic [14:0]  TILE_SPAN   = 15'd20736;
   localparam int unsigned  ZONE_SPAN   = 20736 / ZONE_COUNT;
   localparam logic [7:0]   INDEX_BIAS  = 8'h80;
   localparam logic [7:0]   TALLY_CLAMP = 8'd15;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_COUNT,
      S_HEADER,
      S_DATA
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ZONE_W-1:0] rd_zone;
      logic              upd;
      logic              clr;
   } tally_ctl_type;

   function automatic logic [ZONE_W-1:0] zone_of(input logic [7:0] raw);
      logic [7:0]        idx;
      logic [14:0]       prod;
      logic [14:0]       tile;
      logic [ZONE_W-1:0] zone;
      idx  = raw ^ INDEX_BIAS;
      prod = 15'(idx) * TILE_STRIDE;
      tile = (prod >= TILE_SPAN) ? prod - TILE_SPAN : prod;
      zone = '0;
      for (int k = 1; k < ZONE_COUNT; k++) begin
         if (tile >= 15'(k * ZONE_SPAN)) begin
            zone = ZONE_W'(k);
         end
      end
      return zone;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wbzhp_if.sv =====
// Request and response channel interfaces for the weight block zone header packer.
`default_nettype none

interface wbzhp_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] weight_value;
   logic              block_end;

   modport source (output valid, output weight_value, output block_end, input ready);
   modport sink   (input valid, input weight_value, input block_end, output ready);
endinterface

interface wbzhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/wbzhp_tally.sv =====
// Per-zone tally memory with read-modify-write and running dominant-zone tracking.
`default_nettype none

module wbzhp_tally #(
   parameter int unsigned TW = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wbzhp_pkg::tally_ctl_type      ctl,
   output logic [wbzhp_pkg::ZONE_W-1:0]       lead_zone,
   output logic [TW-1:0]                      lead_count
);
   import wbzhp_pkg::*;

   logic [TW-1:0]     tally_mem [ZONE_COUNT];
   logic [ZONE_COUNT-1:0] valid_ff;
   logic [ZONE_COUNT-1:0] valid_in;
   logic [TW-1:0]     rd_data_ff;
   logic              rd_valid_ff;
   logic [ZONE_W-1:0] zone_ff;
   logic [TW-1:0]     new_tally;
   logic [ZONE_W-1:0] lead_zone_ff;
   logic [ZONE_W-1:0] lead_zone_in;
   logic [TW-1:0]     lead_count_ff;
   logic [TW-1:0]     lead_count_in;

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff  <= tally_mem[ctl.rd_zone];
         rd_valid_ff <= valid_ff[ctl.rd_zone];
         zone_ff     <= ctl.rd_zone;
      end
      if (ctl.upd) begin
         tally_mem[zone_ff] <= new_tally;
      end
   end

   assign new_tally = (rd_valid_ff ? rd_data_ff : '0) + TW'(1);

   always_comb begin
      valid_in      = valid_ff;
      lead_zone_in  = lead_zone_ff;
      lead_count_in = lead_count_ff;
      if (ctl.clr) begin
         valid_in      = '0;
         lead_zone_in  = '0;
         lead_count_in = '0;
      end else if (ctl.upd) begin
         valid_in[zone_ff] = 1'b1;
         if (new_tally > lead_count_ff) begin
            lead_zone_in  = zone_ff;
            lead_count_in = new_tally;
         end else if (new_tally == lead_count_ff && zone_ff < lead_zone_ff) begin
            lead_zone_in = zone_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         lead_zone_ff  <= '0;
         lead_count_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         lead_zone_ff  <= lead_zone_in;
         lead_count_ff <= lead_count_in;
      end
   end

   assign lead_zone  = lead_zone_ff;
   assign lead_count = lead_count_ff;

endmodule

`default_nettype wire

// ===== rtl/weight_block_zone_header_packer_top.sv =====
// Weight block zone header packer: top level with weight store and output sequencer.
//
// Requests carry one signed weight and a block-end mark on req_chan; responses carry
// one byte and a last mark on rsp_chan, both valid/ready, taken when both are high.
// The zone tally of a request is read from its memory in the accepting cycle and
// written back in the next; req_chan.ready stays low for the write-back, so each
// request waits for the last one's tally. Up to BLOCK_WEIGHTS weights are stored;
// later ones in the block are dropped but a block-end mark on them still closes the
// block. After the closing request and its tally update, the count byte enters the
// output register, then the zone-map byte, then each stored weight in offset binary,
// one byte per cycle unless the receiver stalls (read from the weight store and
// prefetched ahead of the output register). A block of n stored weights emits n + 2
// bytes. No request is taken until the last byte enters the output register; the next
// block may begin while that byte still waits. A stalled receiver holds the output
// register and the sequencer. Reset empties the block, the tallies and the output.
`default_nettype none

module weight_block_zone_header_packer_top #(
   parameter int unsigned BLOCK_WEIGHTS = 32
) (
   input wire logic clock,
   input wire logic reset,
   wbzhp_req_if.sink   req_chan,
   wbzhp_rsp_if.source rsp_chan
);
   import wbzhp_pkg::*;

   localparam int unsigned FW = $clog2(BLOCK_WEIGHTS + 1);
   localparam int unsigned AW = (BLOCK_WEIGHTS > 1) ? $clog2(BLOCK_WEIGHTS) : 1;

   state_type     state_ff;
   state_type     state_in;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] idx_ff;
   logic [FW-1:0] idx_in;
   logic          end_ff;
   logic          end_in;
   logic          keep_ff;
   logic          keep_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_byte_ff;
   logic [7:0]    rsp_byte_in;
   logic          rsp_last_ff;
   logic          rsp_last_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    store_mem [BLOCK_WEIGHTS];

   logic               req_fire;
   logic               slot_free;
   logic               has_room;
   logic               data_last;
   logic [7:0]         cnt8;
   logic [3:0]         cnt_nib;
   tally_ctl_type      tally_ctl;
   logic [ZONE_W-1:0]  lead_zone;
   logic [FW-1:0]      lead_count;

   wbzhp_tally #(.TW(FW)) u_tally (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tally_ctl),
      .lead_zone  (lead_zone),
      .lead_count (lead_count)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign has_room  = fill_ff < FW'(BLOCK_WEIGHTS);
   assign data_last = (idx_ff + FW'(1)) == fill_ff;
   assign cnt8      = 8'(lead_count);
   assign cnt_nib   = (cnt8 > TALLY_CLAMP) ? TALLY_CLAMP[3:0] : cnt8[3:0];

   // store the weight and prefetch the next byte to emit
   always_ff @(posedge clock) begin
      if (req_fire && has_room) begin
         store_mem[fill_ff[AW-1:0]] <= req_chan.weight_value;
      end
      rd_data_ff <= store_mem[idx_in[AW-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = end_ff ? S_COUNT : S_IDLE;
         end
         S_COUNT: begin
            if (slot_free) state_in = S_HEADER;
         end
         S_HEADER: begin
            if (slot_free) state_in = (fill_ff == '0) ? S_IDLE : S_DATA;
         end
         S_DATA: begin
            if (slot_free && data_last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      tally_ctl    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               tally_ctl.rd_en   = 1'b1;
               tally_ctl.rd_zone = zone_of(req_chan.weight_value);
               end_in            = req_chan.block_end;
               keep_in           = has_room;
               if (has_room) fill_in = fill_ff + FW'(1);
            end
         end
         S_UPDATE: begin
            tally_ctl.upd = keep_ff;
         end
         S_COUNT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'(fill_ff);
               rsp_last_in  = (fill_ff == '0);
            end
         end
         S_HEADER: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = {lead_zone, cnt_nib};
               rsp_last_in  = (fill_ff == '0);
               if (fill_ff == '0) tally_ctl.clr = 1'b1;
            end
         end
         S_DATA: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff ^ INDEX_BIAS;
               rsp_last_in  = data_last;
               if (data_last) begin
                  idx_in        = '0;
                  fill_in       = '0;
                  tally_ctl.clr = 1'b1;
               end else begin
                  idx_in = idx_ff + FW'(1);
               end
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         end_ff       <= 1'b0;
         keep_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         end_ff       <= end_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;

   a_fire_to_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_UPDATE)
      else $error("accepted request did not enter tally update");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(BLOCK_WEIGHTS))
      else $error("fill level beyond block size");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA |-> (fill_ff != '0) && (idx_ff < fill_ff))
      else $error("emit index outside stored weights");

   a_close_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && end_ff) |=> state_ff == S_COUNT)
      else $error("closed block did not start emission");

endmodule

`default_nettype wire

// ===== sim/weight_block_zone_header_packer_top_tb.sv =====
// Self-checking testbench for the weight block zone header packer.
`timescale 1ns / 1ps

module weight_block_zone_header_packer_top_tb;

   import wbzhp_pkg::*;

   localparam int unsigned BLOCK_WEIGHTS  = 32;
   localparam int unsigned RANDOM_WEIGHTS = 105;
   localparam int unsigned HIT_CLAMP      = 15;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } emitted_byte_type;

   class zone_header_scoreboard;
      int unsigned      zone_hits[ZONE_COUNT];
      logic [7:0]       held_weights[BLOCK_WEIGHTS];
      int unsigned      fill;
      emitted_byte_type pending_bytes[$];
      int unsigned      mismatches;
      int unsigned      bytes_checked;
      int unsigned      blocks_closed;
      int unsigned      weights_taken;

      function void clear_block();
         foreach (zone_hits[z]) zone_hits[z] = 0;
         fill = 0;
      endfunction

      function int unsigned zone_for(logic signed [7:0] w);
         int unsigned offset;
         int unsigned tile;
         offset = int'(w) + 128;
         tile   = (offset * 37) % 20736;
         return tile / (20736 / ZONE_COUNT);
      endfunction

      function void note_request(logic signed [7:0] w, logic closes);
         int unsigned      lead_zone;
         int unsigned      lead_hits;
         emitted_byte_type b;
         weights_taken++;
         if (fill < BLOCK_WEIGHTS) begin
            held_weights[fill] = w;
            zone_hits[zone_for(w)]++;
            fill++;
         end
         if (!closes) return;
         lead_zone = 0;
         lead_hits = 0;
         for (int z = 0; z < ZONE_COUNT; z++) begin
            if (zone_hits[z] > lead_hits) begin
               lead_hits = zone_hits[z];
               lead_zone = z;
            end
         end
         if (lead_hits > HIT_CLAMP) lead_hits = HIT_CLAMP;
         b.value = 8'(fill);
         b.last  = (fill == 0);
         pending_bytes.push_back(b);
         b.value = {4'(lead_zone), 4'(lead_hits)};
         pending_bytes.push_back(b);
         for (int i = 0; i < fill; i++) begin
            b.value = held_weights[i] + 8'd128;
            b.last  = (i + 1 == fill);
            pending_bytes.push_back(b);
         end
         clear_block();
         blocks_closed++;
      endfunction

      function void check_byte(logic [7:0] value, logic last);
         emitted_byte_type b;
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected byte %02h last %0b", $time, value, last);
            mismatches++;
            return;
         end
         b = pending_bytes.pop_front();
         if (b.value !== value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, b.value, value);
            mismatches++;
         end
         if (b.last !== last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, b.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   wbzhp_req_if req_chan();
   wbzhp_rsp_if rsp_chan();

   weight_block_zone_header_packer_top #(
      .BLOCK_WEIGHTS(BLOCK_WEIGHTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   zone_header_scoreboard packer_sb = new();
   int unsigned req_gap_max;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_weight(logic signed [7:0] w, logic closes);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.weight_value <= w;
      req_chan.block_end    <= closes;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      packer_sb.note_request(w, closes);
   endtask

   task automatic send_block(int unsigned len, logic signed [7:0] favored);
      logic signed [7:0] w;
      for (int i = 0; i < len; i++) begin
         w = ($urandom_range(0, 2) == 0) ? favored : 8'($urandom_range(0, 255));
         send_weight(w, i == len - 1);
      end
   endtask

   // response side: random stalls with quiet stretches
   initial begin
      int unsigned gap;
      int unsigned seen;
      bit          quiet;
      rsp_chan.ready <= 1'b0;
      seen  = 0;
      quiet = 1'b0;
      @(negedge reset);
      forever begin
         if (seen % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         packer_sb.check_byte(rsp_chan.out_byte, rsp_chan.out_last);
         seen++;
      end
   end

   initial begin
      int unsigned sent;
      int unsigned len;
      int unsigned blk;
      packer_sb.clear_block();
      req_gap_max           = 19;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.weight_value <= '0;
      req_chan.block_end    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, single-weight blocks, zone tie, tally clamp
      send_weight(-8'sd128, 1'b1);
      send_weight(8'sd127, 1'b1);
      send_weight(8'sd127, 1'b0);
      send_weight(-8'sd128, 1'b1);
      req_gap_max = 0;
      send_weight(8'sd0, 1'b0);
      send_weight(-8'sd1, 1'b1);
      for (int i = 0; i < 17; i++) send_weight(8'sd0, i == 16);
      req_gap_max = 19;

      // overfull blocks first: close on a dropped weight, then well past the limit
      sent = 0;
      blk  = 0;
      while (sent < RANDOM_WEIGHTS) begin
         if (blk == 0)      len = BLOCK_WEIGHTS + 1;
         else if (blk == 1) len = BLOCK_WEIGHTS + 5;
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(28, 40);
         else len = $urandom_range(1, 10);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
         send_block(len, 8'($urandom_range(0, 255)));
         sent += len;
         blk++;
      end
      req_chan.valid <= 1'b0;

      while (packer_sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d weights in %0d blocks, %0d bytes checked",
               packer_sb.weights_taken, packer_sb.blocks_closed, packer_sb.bytes_checked);
      $display("including overfull blocks, zone ties and clamped tallies");
      if (packer_sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout with %0d bytes outstanding", packer_sb.pending_bytes.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
